### rtl/core/tfd_pkg.sv
package tfd_pkg;

  // defaults for the top-level parameters
  localparam int RING_FRAMES_DEF = 262144;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int CHANNELS_DEF    = 2;

  // fixed register field widths
  localparam int TAP_BITS       = 18;
  localparam int FLEN_BITS      = 19;
  localparam int GAIN_BITS      = 16;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 32;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DRY_GAIN        = 4'd0,
    REG_TAP1_DELAY      = 4'd1,
    REG_TAP1_GAINS      = 4'd2,
    REG_TAP2_DELAY      = 4'd3,
    REG_TAP2_GAINS      = 4'd4,
    REG_FEEDBACK_LENGTH = 4'd5,
    REG_FEEDBACK_GAIN   = 4'd6,
    REG_LOWPASS_COEF    = 4'd7
  } reg_index_t;

  localparam logic [GAIN_BITS-1:0]   DRY_GAIN_RST        = 16'd32768;
  localparam logic [TAP_BITS-1:0]    TAP1_DELAY_RST      = 18'd12000;
  localparam logic [31:0]            TAP1_GAINS_RST      = 32'd1076310865;
  localparam logic [TAP_BITS-1:0]    TAP2_DELAY_RST      = 18'd24000;
  localparam logic [31:0]            TAP2_GAINS_RST      = 32'd323690535;
  localparam logic [FLEN_BITS-1:0]   FEEDBACK_LENGTH_RST = 19'd16320;
  localparam logic [GAIN_BITS-1:0]   FEEDBACK_GAIN_RST   = 16'd0;
  localparam logic [GAIN_BITS-1:0]   LOWPASS_COEF_RST    = 16'd8074;

  // one frame's sequence
  typedef enum logic [2:0] {
    S_IDLE,
    S_DRY,
    S_TAP1,
    S_TAP2,
    S_LOWPASS,
    S_OUT,
    S_FB,
    S_DONE
  } state_t;

  // gains the lanes need
  typedef struct packed {
    logic [GAIN_BITS-1:0] dry_gain;
    logic [31:0]          tap1_gains;
    logic [31:0]          tap2_gains;
    logic [GAIN_BITS-1:0] feedback_gain;
    logic [GAIN_BITS-1:0] lowpass_coef;
  } tfd_cfg_t;

  // sequencer to lanes
  typedef struct packed {
    state_t step;
    logic   fire;    // input beat taken this cycle
    logic   commit;  // frame finishes this cycle
    logic   v1;      // tap 1 entry has been written
    logic   v2;
    logic   vfb;     // feedback entry has been written
    logic   byp1;    // tap 1 delay is zero
    logic   byp2;
  } tfd_ctl_t;

endpackage

### rtl/core/tfd_ram.sv
module tfd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/tfd_lane.sv
module tfd_lane #(
  parameter int RING_FRAMES = tfd_pkg::RING_FRAMES_DEF,
  parameter int SAMPLE_BITS = tfd_pkg::SAMPLE_BITS_DEF,
  parameter int LANE        = 0,
  localparam int AW = $clog2(RING_FRAMES)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tfd_pkg::tfd_ctl_t             ctl,
  input  tfd_pkg::tfd_cfg_t             cfg,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [AW-1:0]                 wp,
  input  logic [AW-1:0]                 dl_raddr,
  input  logic [AW-1:0]                 fp,
  output logic signed [SAMPLE_BITS-1:0] result
);

  import tfd_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int PW   = SB + GAIN_BITS + 1;
  localparam int ACCW = SB + 20;
  localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

  function automatic logic signed [SB-1:0] sat(input logic signed [ACCW-1:0] v);
    logic [ACCW-SB:0] top;
    top = v[ACCW-1:SB-1];
    if ((&top) || !(|top)) begin
      sat = v[SB-1:0];
    end else if (v[ACCW-1]) begin
      sat = SMIN;
    end else begin
      sat = SMAX;
    end
  endfunction

  logic signed [SB-1:0]   x;
  logic signed [SB-1:0]   t;
  logic signed [SB-1:0]   y;
  logic signed [SB-1:0]   lp;
  logic signed [PW-1:0]   prod;
  logic signed [ACCW-1:0] acc;

  logic [SB-1:0]          dl_q;
  logic [SB-1:0]          fb_q;
  logic signed [SB-1:0]   fbv;
  logic signed [SB-1:0]   mul_a;
  logic [GAIN_BITS-1:0]   mul_b;
  logic signed [PW-1:0]   prod_c;
  logic [GAIN_BITS-1:0]   g1;
  logic [GAIN_BITS-1:0]   g2;
  logic signed [SB-1:0]   tap_val;
  logic signed [SB-1:0]   fb_val;

  tfd_ram #(.WIDTH(SB), .DEPTH(RING_FRAMES)) u_delay (
    .clk   (clk),
    .we    (ctl.fire),
    .waddr (wp),
    .wdata (sample),
    .raddr (dl_raddr),
    .rdata (dl_q)
  );

  tfd_ram #(.WIDTH(SB), .DEPTH(RING_FRAMES)) u_feedback (
    .clk   (clk),
    .we    (ctl.commit),
    .waddr (fp),
    .wdata (fbv),
    .raddr (fp),
    .rdata (fb_q)
  );

  assign g1 = (LANE == 0) ? cfg.tap1_gains[15:0] : cfg.tap1_gains[31:16];
  assign g2 = (LANE == 0) ? cfg.tap2_gains[15:0] : cfg.tap2_gains[31:16];

  // never-written entries read as zero; zero delay takes the current input
  always_comb begin
    if (ctl.step == S_DRY) begin
      tap_val = ctl.byp1 ? x : (ctl.v1 ? $signed(dl_q) : '0);
    end else begin
      tap_val = ctl.byp2 ? x : (ctl.v2 ? $signed(dl_q) : '0);
    end
    fb_val = ctl.vfb ? $signed(fb_q) : '0;
  end

  always_comb begin
    case (ctl.step)
      S_TAP1: begin
        mul_a = t;
        mul_b = g1;
      end
      S_TAP2: begin
        mul_a = t;
        mul_b = g2;
      end
      S_LOWPASS: begin
        mul_a = lp;
        mul_b = cfg.lowpass_coef;
      end
      S_FB: begin
        mul_a = y;
        mul_b = cfg.feedback_gain;
      end
      default: begin
        mul_a = x;
        mul_b = cfg.dry_gain;
      end
    endcase
  end

  assign prod_c = mul_a * $signed({1'b0, mul_b});
  assign fbv    = sat((acc + ACCW'(prod)) >>> 16);
  assign result = y;

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      x <= sample;
    end
    case (ctl.step)
      S_DRY: begin
        prod <= prod_c;
        acc  <= (ACCW'(fb_val) <<< 15) + ACCW'(16384);
        t    <= tap_val;
      end
      S_TAP1: begin
        prod <= prod_c;
        acc  <= acc + ACCW'(prod);
        t    <= tap_val;
      end
      S_TAP2, S_LOWPASS: begin
        prod <= prod_c;
        acc  <= acc + ACCW'(prod);
      end
      S_OUT: begin
        y   <= sat(acc >>> 15);
        acc <= ACCW'(prod) + ACCW'(32768);
      end
      S_FB: begin
        prod <= prod_c;
      end
      default: begin
      end
    endcase
  end

  // lowpass memory is state: cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      lp <= '0;
    end else if (ctl.commit) begin
      lp <= fbv;
    end
  end

endmodule

### rtl/core/tfd_ctrl.sv
module tfd_ctrl #(
  parameter int RING_FRAMES = tfd_pkg::RING_FRAMES_DEF,
  localparam int AW = $clog2(RING_FRAMES)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [tfd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [tfd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                out_free,
  output tfd_pkg::tfd_cfg_t                   cfg,
  output tfd_pkg::tfd_ctl_t                   ctl,
  output logic [AW-1:0]                       wp,
  output logic [AW-1:0]                       dl_raddr,
  output logic [AW-1:0]                       fp
);

  import tfd_pkg::*;

  localparam int CW = (AW > TAP_BITS) ? AW : TAP_BITS;
  localparam int LW = (AW + 1 > FLEN_BITS) ? AW + 1 : FLEN_BITS;
  localparam logic [AW-1:0] MASK = AW'(RING_FRAMES - 1);

  state_t state, state_next;

  logic [TAP_BITS-1:0]  tap1_delay;
  logic [TAP_BITS-1:0]  tap2_delay;
  logic [FLEN_BITS-1:0] feedback_length;

  logic          wrapped;
  logic [AW:0]   fb_hi;
  logic          v1, v2, vfb, byp1, byp2;

  logic [CW-1:0] d1_ext, d2_ext;
  logic [AW-1:0] d1, d2, i1, i2;
  logic [LW-1:0] fl_ext;
  logic [AW:0]   flen;
  logic [AW:0]   fp_inc;
  logic          fire, commit;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dry_gain      <= DRY_GAIN_RST;
      tap1_delay        <= TAP1_DELAY_RST;
      cfg.tap1_gains    <= TAP1_GAINS_RST;
      tap2_delay        <= TAP2_DELAY_RST;
      cfg.tap2_gains    <= TAP2_GAINS_RST;
      feedback_length   <= FEEDBACK_LENGTH_RST;
      cfg.feedback_gain <= FEEDBACK_GAIN_RST;
      cfg.lowpass_coef  <= LOWPASS_COEF_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DRY_GAIN:        cfg.dry_gain      <= cfg_data[GAIN_BITS-1:0];
        REG_TAP1_DELAY:      tap1_delay        <= cfg_data[TAP_BITS-1:0];
        REG_TAP1_GAINS:      cfg.tap1_gains    <= cfg_data;
        REG_TAP2_DELAY:      tap2_delay        <= cfg_data[TAP_BITS-1:0];
        REG_TAP2_GAINS:      cfg.tap2_gains    <= cfg_data;
        REG_FEEDBACK_LENGTH: feedback_length   <= cfg_data[FLEN_BITS-1:0];
        REG_FEEDBACK_GAIN:   cfg.feedback_gain <= cfg_data[GAIN_BITS-1:0];
        REG_LOWPASS_COEF:    cfg.lowpass_coef  <= cfg_data[GAIN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // clamp delays to the ring, length to 1..RING_FRAMES
  always_comb begin
    d1_ext = CW'(tap1_delay);
    d2_ext = CW'(tap2_delay);
    d1 = (d1_ext > CW'(MASK)) ? MASK : d1_ext[AW-1:0];
    d2 = (d2_ext > CW'(MASK)) ? MASK : d2_ext[AW-1:0];
    i1 = wp - d1;
    i2 = wp - d2;
    fl_ext = LW'(feedback_length);
    if (fl_ext == '0) begin
      flen = (AW + 1)'(1);
    end else if (fl_ext > LW'(RING_FRAMES)) begin
      flen = (AW + 1)'(RING_FRAMES);
    end else begin
      flen = fl_ext[AW:0];
    end
    fp_inc = {1'b0, fp} + (AW + 1)'(1);
  end

  assign fire   = in_valid && in_ready;
  assign commit = (state == S_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    case (state)
      S_IDLE:    state_next = in_valid ? S_DRY : S_IDLE;
      S_DRY:     state_next = S_TAP1;
      S_TAP1:    state_next = S_TAP2;
      S_TAP2:    state_next = S_LOWPASS;
      S_LOWPASS: state_next = S_OUT;
      S_OUT:     state_next = S_FB;
      S_FB:      state_next = S_DONE;
      S_DONE:    state_next = out_free ? S_IDLE : S_DONE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == S_IDLE);
    dl_raddr   = (state == S_DRY) ? i2 : i1;
    ctl.step   = state;
    ctl.fire   = fire;
    ctl.commit = commit;
    ctl.v1     = v1;
    ctl.v2     = v2;
    ctl.vfb    = vfb;
    ctl.byp1   = byp1;
    ctl.byp2   = byp2;
  end

  // written entries form a prefix until the ring wraps
  always_ff @(posedge clk) begin
    if (fire) begin
      v1   <= wrapped || (i1 <= wp);
      v2   <= wrapped || (i2 <= wp);
      vfb  <= ({1'b0, fp} < fb_hi);
      byp1 <= (d1 == '0);
      byp2 <= (d2 == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      fp      <= '0;
      wrapped <= 1'b0;
      fb_hi   <= '0;
    end else if (commit) begin
      wp <= wp + AW'(1);
      if (wp == MASK) begin
        wrapped <= 1'b1;
      end
      fp <= (fp_inc >= flen) ? '0 : fp_inc[AW-1:0];
      if (fp_inc > fb_hi) begin
        fb_hi <= fp_inc;
      end
    end
  end

endmodule

### rtl/core/two_tap_feedback_delay.sv
// Two-tap stereo delay with a lowpass-filtered feedback line. Each input beat is one
// frame of signed Q1.(SAMPLE_BITS-1) samples and yields exactly one output beat. A frame
// is written into the delay ring first, so a tap delay of zero hears the current input;
// each channel sums dry, two taps and the current feedback entry, rounds and saturates.
// The feedback value (one-pole lowpass of the output) goes to the lowpass memory and the
// feedback line. A new frame is taken only once the last has run the steps DRY, TAP1,
// TAP2, LOWPASS, OUT, FB and DONE (held until the output is free). The single multiplier
// per channel is used five times per frame. Each channel lane owns two RAMs of
// RING_FRAMES x SAMPLE_BITS; lines start out as zeros through fill marks, so there is no
// clearing pass after reset and a frame may be sent right away. Config writes are always
// ready; write them only while the block is idle. Unknown register indexes are ignored.
module two_tap_feedback_delay #(
  parameter int RING_FRAMES = tfd_pkg::RING_FRAMES_DEF,
  parameter int SAMPLE_BITS = tfd_pkg::SAMPLE_BITS_DEF,
  parameter int CHANNELS    = tfd_pkg::CHANNELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // input frame beats
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [SAMPLE_BITS-1:0]      left_sample,
  input  logic signed [SAMPLE_BITS-1:0]      right_sample,
  // output frame beats
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [SAMPLE_BITS-1:0]      left_out,
  output logic signed [SAMPLE_BITS-1:0]      right_out,
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tfd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tfd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  import tfd_pkg::*;

  localparam int AW = $clog2(RING_FRAMES);

  tfd_cfg_t cfg;
  tfd_ctl_t ctl;

  logic [AW-1:0] wp;
  logic [AW-1:0] dl_raddr;
  logic [AW-1:0] fp;
  logic          out_free;

  logic signed [SAMPLE_BITS-1:0] smp    [2];
  logic signed [SAMPLE_BITS-1:0] lane_y [2];

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign smp[0]    = left_sample;
  assign smp[1]    = right_sample;

  // sequencer, register file, pointers and fill marks
  tfd_ctrl #(.RING_FRAMES(RING_FRAMES)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_free  (out_free),
    .cfg       (cfg),
    .ctl       (ctl),
    .wp        (wp),
    .dl_raddr  (dl_raddr),
    .fp        (fp)
  );

  // one lane per channel; an unused channel reads as zero
  for (genvar c = 0; c < 2; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      tfd_lane #(
        .RING_FRAMES (RING_FRAMES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .LANE        (c)
      ) u_lane (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .cfg      (cfg),
        .sample   (smp[c]),
        .wp       (wp),
        .dl_raddr (dl_raddr),
        .fp       (fp),
        .result   (lane_y[c])
      );
    end else begin : g_off
      assign lane_y[c] = '0;
    end
  end

  // merge stage: output register, loaded when a frame finishes; it frees the
  // sequencer to take the next input beat while this result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      left_out  <= lane_y[0];
      right_out <= lane_y[1];
    end
  end

endmodule
